// ----- design/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Antecedent implies consequent in the following cycle.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ----- design/hbmt_pkg.sv -----
// Types, result codes and helper functions of the heartbeat membership table.
package hbmt_pkg;

    localparam int KIND_W  = 3;
    localparam int COUNT_W = 7;
    localparam int ADDR_W  = 8;

    localparam logic [KIND_W-1:0] KIND_ADDED     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_UPDATED   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_UNCHANGED = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SELF      = 3'd3;
    localparam logic [KIND_W-1:0] KIND_STALE     = 3'd4;
    localparam logic [KIND_W-1:0] KIND_FULL      = 3'd5;
    localparam logic [KIND_W-1:0] KIND_REMOVED   = 3'd6;
    localparam logic [KIND_W-1:0] KIND_TICK_DONE = 3'd7;

    localparam logic [ADDR_W-1:0] REG_FAIL_TIMEOUT   = 8'd0;
    localparam logic [ADDR_W-1:0] REG_REMOVE_TIMEOUT = 8'd1;
    localparam logic [ADDR_W-1:0] REG_SELF_ID        = 8'd2;
    localparam logic [ADDR_W-1:0] REG_SELF_PORT      = 8'd3;

    localparam logic [7:0] FAIL_TIMEOUT_RST   = 8'd5;
    localparam logic [7:0] REMOVE_TIMEOUT_RST = 8'd20;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESULT,
        ST_EMIT_RD,
        ST_EMIT_OUT,
        ST_TICK_DONE
    } hbmt_state_t;

    typedef struct packed {
        logic [31:0] ident;
        logic [15:0] port;
        logic [31:0] beat;
        logic [31:0] stamp;
    } hbmt_entry_t;

    // True when a heartbeat or stamp plus both timeouts does not exceed the clock.
    function automatic logic hbmt_expired(input logic [31:0] beat,
                                          input logic [7:0]  fail_to,
                                          input logic [7:0]  remove_to,
                                          input logic [31:0] clock);
        logic [33:0] lim;
        lim = {2'b00, beat} + {26'd0, fail_to} + {26'd0, remove_to};
        return lim <= {2'b00, clock};
    endfunction

endpackage

// ----- design/heartbeat_membership_table.sv -----
// A self or stale report goes straight from the idle state to its result state; any
// other report first scans the table through the RAM read port, then gives its result.
// A tick scans once for expiry, then re-reads each removed entry through the RAM read
// port to emit it, skipping the other slots, and ends with its tick-done result.
// The next item is taken once the current one's last result sits in the output register.
// Synchronous active-low reset clears the valid bits at once; the table RAM needs no pass.
module heartbeat_membership_table #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [hbmt_pkg::ADDR_W-1:0]       cfg_addr,
    input  logic [31:0]                       cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_action,
    input  logic [31:0]                       s_member_id,
    input  logic [15:0]                       s_member_port,
    input  logic [31:0]                       s_member_heartbeat,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [hbmt_pkg::KIND_W-1:0]       m_kind,
    output logic [31:0]                       m_entry_id,
    output logic [15:0]                       m_entry_port,
    output logic                              m_gossip_due,
    output logic [hbmt_pkg::COUNT_W-1:0]      m_member_count,
    output logic                              m_last
);

    import hbmt_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [IDX_W:0]   SCAN_LIMIT = (IDX_W + 1)'(TABLE_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(TABLE_DEPTH - 1);

    hbmt_state_t state_reg, state_next;

    logic [7:0]  fail_to_reg, fail_to_next;
    logic [7:0]  remove_to_reg, remove_to_next;
    logic [31:0] self_id_reg, self_id_next;
    logic [15:0] self_port_reg, self_port_next;

    logic [31:0] clock_reg, clock_next;
    logic [7:0]  countdown_reg, countdown_next;
    logic [7:0]  countdown_dec;
    logic [CNT_W-1:0] total_reg, total_next;
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic [TABLE_DEPTH-1:0] rm_mask_reg, rm_mask_next;

    logic        op_tick_reg, op_tick_next;
    logic [31:0] req_id_reg, req_id_next;
    logic [15:0] req_port_reg, req_port_next;
    logic [31:0] req_beat_reg, req_beat_next;
    logic [KIND_W-1:0] kind_reg, kind_next;
    logic        due_reg, due_next;

    logic [IDX_W:0]   scan_cnt_reg, scan_cnt_next;
    logic             chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0] chk_idx_reg, chk_idx_next;
    logic             hit_found_reg, hit_found_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic             hit_newer_reg, hit_newer_next;
    logic             free_found_reg, free_found_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;

    logic              m_valid_reg, m_valid_next;
    logic [KIND_W-1:0] m_kind_reg, m_kind_next;
    logic [31:0]       m_id_reg, m_id_next;
    logic [15:0]       m_port_reg, m_port_next;
    logic              m_due_reg, m_due_next;
    logic [COUNT_W-1:0] m_count_reg, m_count_next;
    logic              m_last_reg, m_last_next;

    logic ram_we;
    logic [IDX_W-1:0] ram_waddr;
    hbmt_entry_t ram_wdata, ram_rdata;
    logic [$bits(hbmt_entry_t)-1:0] ram_rdata_raw;

    logic accept, self_hit, stale_hit, out_free, scan_end;
    logic chk_slot_valid, chk_match;
    logic hit_any, newer_any, free_any;
    logic [IDX_W-1:0] hit_sel, free_sel;

    hbmt_ram #(
        .WIDTH ($bits(hbmt_entry_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (scan_cnt_reg[IDX_W-1:0]),
        .rdata (ram_rdata_raw)
    );

    assign ram_rdata = hbmt_entry_t'(ram_rdata_raw);

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;

    assign self_hit  = (s_member_id == self_id_reg) && (s_member_port == self_port_reg);
    assign stale_hit = hbmt_expired(s_member_heartbeat, fail_to_reg, remove_to_reg, clock_reg);
    assign countdown_dec = countdown_reg - 8'd1;

    assign scan_end       = chk_vld_reg && (chk_idx_reg == LAST_IDX);
    assign chk_slot_valid = valid_reg[chk_idx_reg];
    assign chk_match      = chk_vld_reg && chk_slot_valid
                            && (ram_rdata.ident == req_id_reg)
                            && (ram_rdata.port == req_port_reg);

    // Merge the entry under comparison with what earlier slots found, so the last slot counts.
    assign hit_any   = hit_found_reg || chk_match;
    assign hit_sel   = hit_found_reg ? hit_idx_reg : chk_idx_reg;
    assign newer_any = hit_found_reg ? hit_newer_reg : (ram_rdata.beat < req_beat_reg);
    assign free_any  = free_found_reg || (chk_vld_reg && !chk_slot_valid);
    assign free_sel  = free_found_reg ? free_idx_reg : chk_idx_reg;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (!s_action && (self_hit || stale_hit)) begin
                        state_next = ST_RESULT;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (scan_end) begin
                    state_next = op_tick_reg ? ST_EMIT_RD : ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT_RD: begin
                if (scan_cnt_reg == SCAN_LIMIT) begin
                    state_next = ST_TICK_DONE;
                end else if (rm_mask_reg[scan_cnt_reg[IDX_W-1:0]]) begin
                    state_next = ST_EMIT_OUT;
                end
            end
            ST_EMIT_OUT: begin
                if (out_free) begin
                    state_next = ST_EMIT_RD;
                end
            end
            ST_TICK_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        fail_to_next    = fail_to_reg;
        remove_to_next  = remove_to_reg;
        self_id_next    = self_id_reg;
        self_port_next  = self_port_reg;
        clock_next      = clock_reg;
        countdown_next  = countdown_reg;
        total_next      = total_reg;
        valid_next      = valid_reg;
        rm_mask_next    = rm_mask_reg;
        op_tick_next    = op_tick_reg;
        req_id_next     = req_id_reg;
        req_port_next   = req_port_reg;
        req_beat_next   = req_beat_reg;
        kind_next       = kind_reg;
        due_next        = due_reg;
        scan_cnt_next   = scan_cnt_reg;
        chk_vld_next    = 1'b0;
        chk_idx_next    = chk_idx_reg;
        hit_found_next  = hit_found_reg;
        hit_idx_next    = hit_idx_reg;
        hit_newer_next  = hit_newer_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_kind_next     = m_kind_reg;
        m_id_next       = m_id_reg;
        m_port_next     = m_port_reg;
        m_due_next      = m_due_reg;
        m_count_next    = m_count_reg;
        m_last_next     = m_last_reg;
        ram_we          = 1'b0;
        ram_waddr       = free_sel;
        ram_wdata       = '{ident: req_id_reg, port: req_port_reg,
                            beat: req_beat_reg, stamp: clock_reg};

        if (cfg_valid && cfg_ready) begin
            unique case (cfg_addr)
                REG_FAIL_TIMEOUT:   fail_to_next   = cfg_data[7:0];
                REG_REMOVE_TIMEOUT: remove_to_next = cfg_data[7:0];
                REG_SELF_ID:        self_id_next   = cfg_data;
                REG_SELF_PORT:      self_port_next = cfg_data[15:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    op_tick_next    = s_action;
                    req_id_next     = s_member_id;
                    req_port_next   = s_member_port;
                    req_beat_next   = s_member_heartbeat;
                    scan_cnt_next   = '0;
                    hit_found_next  = 1'b0;
                    free_found_next = 1'b0;
                    kind_next       = self_hit ? KIND_SELF : KIND_STALE;
                    if (s_action) begin
                        clock_next   = clock_reg + 32'd1;
                        rm_mask_next = '0;
                        if (countdown_dec == 8'd0) begin
                            due_next       = 1'b1;
                            countdown_next = fail_to_reg;
                        end else begin
                            due_next       = 1'b0;
                            countdown_next = countdown_dec;
                        end
                    end
                end
            end
            ST_SCAN: begin
                if (scan_cnt_reg < SCAN_LIMIT) begin
                    chk_vld_next  = 1'b1;
                    chk_idx_next  = scan_cnt_reg[IDX_W-1:0];
                    scan_cnt_next = scan_cnt_reg + (IDX_W + 1)'(1);
                end
                if (chk_vld_reg) begin
                    if (op_tick_reg) begin
                        if (chk_slot_valid && hbmt_expired(ram_rdata.stamp, fail_to_reg,
                                                           remove_to_reg, clock_reg)) begin
                            valid_next[chk_idx_reg]   = 1'b0;
                            rm_mask_next[chk_idx_reg] = 1'b1;
                            total_next                = total_reg - CNT_W'(1);
                        end
                    end else begin
                        hit_found_next  = hit_any;
                        hit_idx_next    = hit_sel;
                        hit_newer_next  = newer_any;
                        free_found_next = free_any;
                        free_idx_next   = free_sel;
                    end
                end
                if (scan_end) begin
                    scan_cnt_next = '0;
                    if (!op_tick_reg) begin
                        if (hit_any) begin
                            kind_next = newer_any ? KIND_UPDATED : KIND_UNCHANGED;
                            ram_we    = newer_any;
                            ram_waddr = hit_sel;
                        end else if (free_any) begin
                            kind_next            = KIND_ADDED;
                            ram_we               = 1'b1;
                            ram_waddr            = free_sel;
                            valid_next[free_sel] = 1'b1;
                            total_next           = total_reg + CNT_W'(1);
                        end else begin
                            kind_next = KIND_FULL;
                        end
                    end
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = kind_reg;
                    m_id_next    = req_id_reg;
                    m_port_next  = req_port_reg;
                    m_due_next   = 1'b0;
                    m_count_next = COUNT_W'(total_reg);
                    m_last_next  = 1'b1;
                end
            end
            ST_EMIT_RD: begin
                if (scan_cnt_reg != SCAN_LIMIT && !rm_mask_reg[scan_cnt_reg[IDX_W-1:0]]) begin
                    scan_cnt_next = scan_cnt_reg + (IDX_W + 1)'(1);
                end
            end
            ST_EMIT_OUT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_kind_next   = KIND_REMOVED;
                    m_id_next     = ram_rdata.ident;
                    m_port_next   = ram_rdata.port;
                    m_due_next    = 1'b0;
                    m_count_next  = COUNT_W'(total_reg);
                    m_last_next   = 1'b0;
                    scan_cnt_next = scan_cnt_reg + (IDX_W + 1)'(1);
                end
            end
            ST_TICK_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = KIND_TICK_DONE;
                    m_id_next    = '0;
                    m_port_next  = '0;
                    m_due_next   = due_reg;
                    m_count_next = COUNT_W'(total_reg);
                    m_last_next  = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            fail_to_reg   <= FAIL_TIMEOUT_RST;
            remove_to_reg <= REMOVE_TIMEOUT_RST;
            self_id_reg   <= '0;
            self_port_reg <= '0;
            clock_reg     <= '0;
            countdown_reg <= FAIL_TIMEOUT_RST;
            total_reg     <= '0;
            valid_reg     <= '0;
            chk_vld_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            fail_to_reg   <= fail_to_next;
            remove_to_reg <= remove_to_next;
            self_id_reg   <= self_id_next;
            self_port_reg <= self_port_next;
            clock_reg     <= clock_next;
            countdown_reg <= countdown_next;
            total_reg     <= total_next;
            valid_reg     <= valid_next;
            chk_vld_reg   <= chk_vld_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rm_mask_reg    <= rm_mask_next;
        op_tick_reg    <= op_tick_next;
        req_id_reg     <= req_id_next;
        req_port_reg   <= req_port_next;
        req_beat_reg   <= req_beat_next;
        kind_reg       <= kind_next;
        due_reg        <= due_next;
        scan_cnt_reg   <= scan_cnt_next;
        chk_idx_reg    <= chk_idx_next;
        hit_found_reg  <= hit_found_next;
        hit_idx_reg    <= hit_idx_next;
        hit_newer_reg  <= hit_newer_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        m_kind_reg     <= m_kind_next;
        m_id_reg       <= m_id_next;
        m_port_reg     <= m_port_next;
        m_due_reg      <= m_due_next;
        m_count_reg    <= m_count_next;
        m_last_reg     <= m_last_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_kind         = m_kind_reg;
    assign m_entry_id     = m_id_reg;
    assign m_entry_port   = m_port_reg;
    assign m_gossip_due   = m_due_reg;
    assign m_member_count = m_count_reg;
    assign m_last         = m_last_reg;

endmodule

// ----- design/hbmt_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module hbmt_ram #(
    parameter int WIDTH = 112,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- design/hbmt_checker.sv -----
// Port-level checker of the membership table's result channel, with its bind.
`include "assert_macros.svh"

module hbmt_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [hbmt_pkg::KIND_W-1:0] m_kind,
    input logic                        m_gossip_due,
    input logic                        m_last
);

    import hbmt_pkg::*;

    logic stalled;
    logic report_beat;

    assign stalled     = m_valid && !m_ready;
    assign report_beat = m_valid && m_kind != KIND_REMOVED && m_kind != KIND_TICK_DONE;

    // A stalled result beat must hold.
    `ASSERT_NEXT(a_hold, aclk, aresetn, stalled, m_valid && $stable(m_kind) && $stable(m_last))
    // A tick always ends with its tick-done beat.
    `ASSERT_SAME(a_tick_last, aclk, aresetn, m_valid && m_kind == KIND_TICK_DONE, m_last)
    // A removal beat is never the last beat of its tick.
    `ASSERT_SAME(a_removed_not_last, aclk, aresetn, m_valid && m_kind == KIND_REMOVED, !m_last)
    // Only the tick-done beat may carry the gossip flag.
    `ASSERT_SAME(a_due_on_tick, aclk, aresetn, m_valid && m_gossip_due, m_kind == KIND_TICK_DONE)
    // A report gives a single beat.
    `ASSERT_SAME(a_report_single, aclk, aresetn, report_beat, m_last)

endmodule

bind heartbeat_membership_table hbmt_checker u_hbmt_checker (.*);
